### src/bcos_pkg.sv
// Shared constants, side codes and arithmetic helpers for the box collision block.
package bcos_pkg;

    localparam int COORD_BITS = 16;
    localparam int OVL_BITS   = 16;
    localparam int SIDE_BITS  = 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [COORD_BITS:0]   wide_t;
    typedef logic [COORD_BITS-1:0]        ovl_t;
    typedef logic [OVL_BITS-1:0]          ovl_out_t;

    typedef enum logic [SIDE_BITS-1:0] {
        SIDE_NONE  = 3'd0,
        SIDE_UP    = 3'd1,
        SIDE_DOWN  = 3'd2,
        SIDE_LEFT  = 3'd3,
        SIDE_RIGHT = 3'd4
    } side_t;

    // Divide by two, truncating toward zero.
    function automatic coord_t half_trunc(input wide_t s);
        logic signed [COORD_BITS+1:0] t;
        t = {s[COORD_BITS], s} + {{(COORD_BITS+1){1'b0}}, s[COORD_BITS]};
        return t[COORD_BITS:1];
    endfunction

    function automatic wide_t sext1(input coord_t a);
        return {a[COORD_BITS-1], a};
    endfunction

    // Clamp an overlap to the result field width.
    function automatic ovl_out_t sat_ovl(input ovl_t v);
        logic [COORD_BITS+OVL_BITS-1:0] w;
        logic [COORD_BITS+OVL_BITS-1:0] lim;
        w   = (COORD_BITS+OVL_BITS)'(v);
        lim = {{COORD_BITS{1'b0}}, {OVL_BITS{1'b1}}};
        if (w > lim)
            return {OVL_BITS{1'b1}};
        else
            return w[OVL_BITS-1:0];
    endfunction

endpackage

### src/box_collision_overlap_side.sv
// Pipelined box pair collision test with overlap depth and contact side.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  command  | start / busy       | first_* and second_* edges
//  result   | done (strobe)      | hit, overlap_x, overlap_y, contact_side,
//           |                    | detail_side
//
// Five register stages: edge sums, centers and half sizes, magnitudes,
// hit and overlaps, side select. Done strobes once a pair has passed them all;
// one pair can be taken every cycle, so busy is always low.
// Reset clears the stage valid bits only. The receiver cannot stall.
module box_collision_overlap_side
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [bcos_pkg::COORD_BITS-1:0] first_left,
    input  logic signed [bcos_pkg::COORD_BITS-1:0] first_top,
    input  logic signed [bcos_pkg::COORD_BITS-1:0] first_right,
    input  logic signed [bcos_pkg::COORD_BITS-1:0] first_bottom,
    input  logic signed [bcos_pkg::COORD_BITS-1:0] second_left,
    input  logic signed [bcos_pkg::COORD_BITS-1:0] second_top,
    input  logic signed [bcos_pkg::COORD_BITS-1:0] second_right,
    input  logic signed [bcos_pkg::COORD_BITS-1:0] second_bottom,
    output logic                                  done,
    output logic                                  hit,
    output logic [bcos_pkg::OVL_BITS-1:0]         overlap_x,
    output logic [bcos_pkg::OVL_BITS-1:0]         overlap_y,
    output logic [bcos_pkg::SIDE_BITS-1:0]        contact_side,
    output logic [bcos_pkg::SIDE_BITS-1:0]        detail_side
);

    localparam int W = bcos_pkg::COORD_BITS;

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // stage 1: edge sums and sizes
    logic                v1_reg;
    bcos_pkg::wide_t     sx1_reg, sy1_reg, sx2_reg, sy2_reg;
    bcos_pkg::wide_t     wx1_reg, wy1_reg, wx2_reg, wy2_reg;

    // stage 2: center differences and summed half sizes
    logic                v2_reg;
    bcos_pkg::wide_t     dx2_reg, dy2_reg, hx2_reg, hy2_reg;
    bcos_pkg::coord_t    cx1, cy1, cx2, cy2;
    bcos_pkg::coord_t    hw1, hh1, hw2, hh2;

    // stage 3: magnitudes and signs
    logic                v3_reg;
    logic [W:0]          adx_reg, ady_reg;
    logic                dxp3_reg, dxn3_reg, dyp3_reg, dyn3_reg;
    bcos_pkg::wide_t     hx3_reg, hy3_reg;

    // stage 4: hit and overlaps
    logic                v4_reg;
    logic                hit4_reg;
    bcos_pkg::ovl_t      ox4_reg, oy4_reg;
    logic                dxp4_reg, dxn4_reg, dyp4_reg, dyn4_reg;
    logic signed [W+1:0] hx_e, hy_e, adx_e, ady_e, oxd, oyd;
    logic                hitx, hity;

    // stage 5: output
    logic                done_reg;
    logic                hit_reg;
    bcos_pkg::ovl_out_t  ovx_reg, ovy_reg;
    bcos_pkg::side_t     side_reg, detail_reg;
    bcos_pkg::side_t     side_next, detail_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sx1_reg <= bcos_pkg::sext1(first_left) + bcos_pkg::sext1(first_right);
            sy1_reg <= bcos_pkg::sext1(first_top) + bcos_pkg::sext1(first_bottom);
            sx2_reg <= bcos_pkg::sext1(second_left) + bcos_pkg::sext1(second_right);
            sy2_reg <= bcos_pkg::sext1(second_top) + bcos_pkg::sext1(second_bottom);
            wx1_reg <= bcos_pkg::sext1(first_right) - bcos_pkg::sext1(first_left);
            wy1_reg <= bcos_pkg::sext1(first_bottom) - bcos_pkg::sext1(first_top);
            wx2_reg <= bcos_pkg::sext1(second_right) - bcos_pkg::sext1(second_left);
            wy2_reg <= bcos_pkg::sext1(second_bottom) - bcos_pkg::sext1(second_top);
        end
    end

    always_comb
    begin
        cx1 = bcos_pkg::half_trunc(sx1_reg);
        cy1 = bcos_pkg::half_trunc(sy1_reg);
        cx2 = bcos_pkg::half_trunc(sx2_reg);
        cy2 = bcos_pkg::half_trunc(sy2_reg);
        hw1 = bcos_pkg::half_trunc(wx1_reg);
        hh1 = bcos_pkg::half_trunc(wy1_reg);
        hw2 = bcos_pkg::half_trunc(wx2_reg);
        hh2 = bcos_pkg::half_trunc(wy2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            dx2_reg <= bcos_pkg::sext1(cx1) - bcos_pkg::sext1(cx2);
            dy2_reg <= bcos_pkg::sext1(cy1) - bcos_pkg::sext1(cy2);
            hx2_reg <= bcos_pkg::sext1(hw1) + bcos_pkg::sext1(hw2);
            hy2_reg <= bcos_pkg::sext1(hh1) + bcos_pkg::sext1(hh2);
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            adx_reg  <= dx2_reg[W] ? (W+1)'(-dx2_reg) : dx2_reg;
            ady_reg  <= dy2_reg[W] ? (W+1)'(-dy2_reg) : dy2_reg;
            dxn3_reg <= dx2_reg[W];
            dyn3_reg <= dy2_reg[W];
            dxp3_reg <= !dx2_reg[W] && (dx2_reg != '0);
            dyp3_reg <= !dy2_reg[W] && (dy2_reg != '0);
            hx3_reg  <= hx2_reg;
            hy3_reg  <= hy2_reg;
        end
    end

    always_comb
    begin
        hx_e  = {hx3_reg[W], hx3_reg};
        hy_e  = {hy3_reg[W], hy3_reg};
        adx_e = {1'b0, adx_reg};
        ady_e = {1'b0, ady_reg};
        hitx  = adx_e < hx_e;
        hity  = ady_e < hy_e;
        oxd   = hx_e - adx_e;
        oyd   = hy_e - ady_e;
    end

    always_ff @(posedge clk)
    begin
        if (v3_reg)
        begin
            hit4_reg <= hitx && hity;
            // overlap is below 2^W whenever there is a hit
            ox4_reg  <= oxd[W-1:0];
            oy4_reg  <= oyd[W-1:0];
            dxp4_reg <= dxp3_reg;
            dxn4_reg <= dxn3_reg;
            dyp4_reg <= dyp3_reg;
            dyn4_reg <= dyn3_reg;
        end
    end

    always_comb
    begin
        side_next   = bcos_pkg::SIDE_NONE;
        detail_next = bcos_pkg::SIDE_NONE;
        if (ox4_reg >= oy4_reg)
        begin
            if (dyp4_reg || dyn4_reg)
            begin
                side_next   = dyp4_reg ? bcos_pkg::SIDE_UP : bcos_pkg::SIDE_DOWN;
                detail_next = dxp4_reg ? bcos_pkg::SIDE_RIGHT : bcos_pkg::SIDE_LEFT;
            end
        end
        else
        begin
            if (dxp4_reg || dxn4_reg)
            begin
                side_next   = dxp4_reg ? bcos_pkg::SIDE_LEFT : bcos_pkg::SIDE_RIGHT;
                detail_next = dyp4_reg ? bcos_pkg::SIDE_DOWN : bcos_pkg::SIDE_UP;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v4_reg)
        begin
            if (hit4_reg)
            begin
                hit_reg    <= 1'b1;
                ovx_reg    <= bcos_pkg::sat_ovl(ox4_reg);
                ovy_reg    <= bcos_pkg::sat_ovl(oy4_reg);
                side_reg   <= side_next;
                detail_reg <= detail_next;
            end
            else
            begin
                hit_reg    <= 1'b0;
                ovx_reg    <= '0;
                ovy_reg    <= '0;
                side_reg   <= bcos_pkg::SIDE_NONE;
                detail_reg <= bcos_pkg::SIDE_NONE;
            end
        end
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign overlap_x    = ovx_reg;
    assign overlap_y    = ovy_reg;
    assign contact_side = side_reg;
    assign detail_side  = detail_reg;

endmodule
